>>> src/acclk_pkg.sv
// -----------------------------------------------------------------------------
// Access code check package
// Status codes, register indexes, widths and reset values shared by the block.
// -----------------------------------------------------------------------------
package acclk_pkg;

	localparam int CODE_DIGITS = 6;

	localparam int CODE_W  = 20;
	localparam int TIME_W  = 32;
	localparam int LIMIT_W = 8;
	localparam int CHAR_W  = 8;
	localparam int COUNT_W = 4;
	localparam int FAIL_W  = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CODE_W-1:0]  ACC_MAX       = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
	localparam logic [FAIL_W-1:0]  FAIL_MAX      = '1;
	localparam logic [TIME_W-1:0]  LIFETIME_RST  = 32'd300000;
	localparam logic [LIMIT_W-1:0] LIMIT_RST     = 8'd5;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 8'h30;
	localparam logic [CHAR_W-1:0]  CHAR_NINE     = 8'h39;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_INVALID      = 2'd1,
		ST_RATE_LIMITED = 2'd2,
		ST_EXPIRED      = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CODE_VALUE    = 2'd0,
		REG_ISSUE_TIME    = 2'd1,
		REG_LIFETIME_MS   = 2'd2,
		REG_FAILURE_LIMIT = 2'd3
	} reg_idx_t;

endpackage

>>> src/access_code_check_with_lockout_unit.sv
// -----------------------------------------------------------------------------
// Access code check with lockout
// Builds a decimal candidate from characters and judges it on the last one.
// -----------------------------------------------------------------------------
//  channel | signals                               | direction | transfer when
//  --------+---------------------------------------+-----------+----------------------
//  char    | char_valid char_stall char_code ...   | in        | valid & !stall
//  result  | result_valid result_stall status ...  | out       | valid & !stall
//  cfg     | cfg_we cfg_index cfg_wdata            | in        | cfg_we
//
//  One character per cycle unless a last character is held: an item waits in
//  the input register and its result, if any, is loaded into the result
//  register as the item leaves it; the combinational accumulate and judge
//  path sets the rate.
//  arst_n clears state, configuration to reset values and both valid flags.
//  A last character waits in the input register while the result register is
//  full and stalled; characters that are not last pass through regardless.
// -----------------------------------------------------------------------------
module access_code_check_with_lockout_unit
	import acclk_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_stall,
	input  logic [CHAR_W-1:0]     char_code,
	input  logic                  has_char,
	input  logic                  is_last,
	input  logic [TIME_W-1:0]     now_ms,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [1:0]            status,
	output logic [FAIL_W-1:0]     failure_count,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// configuration
	logic [CODE_W-1:0]  code_value_q;
	logic [TIME_W-1:0]  issue_time_q;
	logic [TIME_W-1:0]  lifetime_q;
	logic [LIMIT_W-1:0] limit_q;

	// candidate and lockout state
	logic [CODE_W-1:0]  acc_q;
	logic [COUNT_W-1:0] count_q;
	logic               bad_q;
	logic [FAIL_W-1:0]  fail_q;
	logic               locked_q;

	// input register
	logic               valid_s1;
	logic [CHAR_W-1:0]  char_s1;
	logic               has_s1;
	logic               last_s1;
	logic [TIME_W-1:0]  now_s1;

	// result register
	logic               res_valid_q;
	status_t            status_q;
	logic [FAIL_W-1:0]  fail_out_q;

	logic               out_free;
	logic               advance;
	logic               take_in;

	logic               is_digit;
	logic [CODE_W+3:0]  acc_x10;
	logic [CODE_W+3:0]  acc_sum;
	logic [CODE_W-1:0]  acc_n;
	logic [COUNT_W-1:0] count_n;
	logic               bad_n;
	logic [TIME_W-1:0]  elapsed;
	logic               expired;
	logic               match;
	logic [FAIL_W-1:0]  fail_inc;
	status_t            status_n;
	logic [FAIL_W-1:0]  fail_n;
	logic               locked_n;

	assign out_free   = !res_valid_q || !result_stall;
	assign advance    = valid_s1 && (!last_s1 || out_free);
	assign char_stall = valid_s1 && !advance;
	assign take_in    = char_valid && !char_stall;

	// accumulate the character in hand
	always_comb begin
		is_digit = (char_s1 >= CHAR_ZERO) && (char_s1 <= CHAR_NINE);
		acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
		acc_sum  = acc_x10 + {{CODE_W{1'b0}}, char_s1[3:0]};
		acc_n    = acc_q;
		count_n  = count_q;
		bad_n    = bad_q;
		if (has_s1) begin
			if (count_q != COUNT_MAX)
				count_n = count_q + COUNT_W'(1);
			if (!is_digit) begin
				bad_n = 1'b1;
			end else if (acc_sum > {4'b0000, ACC_MAX}) begin
				bad_n = 1'b1;
				acc_n = ACC_MAX;
			end else begin
				acc_n = acc_sum[CODE_W-1:0];
			end
		end
	end

	// judge on the last character
	always_comb begin
		elapsed  = now_s1 - issue_time_q;
		expired  = elapsed > lifetime_q;
		match    = (count_n == COUNT_W'(CODE_DIGITS)) && !bad_n && (acc_n == code_value_q);
		fail_inc = (fail_q != FAIL_MAX) ? fail_q + FAIL_W'(1) : fail_q;
		status_n = ST_INVALID;
		fail_n   = fail_q;
		locked_n = locked_q;
		if (locked_q) begin
			status_n = ST_RATE_LIMITED;
		end else if (expired) begin
			status_n = ST_EXPIRED;
		end else if (match) begin
			status_n = ST_OK;
			fail_n   = '0;
		end else begin
			fail_n = fail_inc;
			if (fail_inc >= limit_q) begin
				status_n = ST_RATE_LIMITED;
				locked_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_value_q <= '0;
			issue_time_q <= '0;
			lifetime_q   <= LIFETIME_RST;
			limit_q      <= LIMIT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_CODE_VALUE:    code_value_q <= cfg_wdata[CODE_W-1:0];
				REG_ISSUE_TIME:    issue_time_q <= cfg_wdata[TIME_W-1:0];
				REG_LIFETIME_MS:   lifetime_q   <= cfg_wdata[TIME_W-1:0];
				REG_FAILURE_LIMIT: limit_q      <= cfg_wdata[LIMIT_W-1:0];
				default:           ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in || advance) begin
			valid_s1 <= take_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			char_s1 <= char_code;
			has_s1  <= has_char;
			last_s1 <= is_last;
			now_s1  <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			count_q  <= '0;
			bad_q    <= 1'b0;
			fail_q   <= '0;
			locked_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				// start the next candidate afresh
				acc_q    <= '0;
				count_q  <= '0;
				bad_q    <= 1'b0;
				fail_q   <= fail_n;
				locked_q <= locked_n;
			end else begin
				acc_q   <= acc_n;
				count_q <= count_n;
				bad_q   <= bad_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= advance && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q   <= status_n;
			fail_out_q <= fail_n;
		end
	end

	assign result_valid  = res_valid_q;
	assign status        = status_q;
	assign failure_count = fail_out_q;

	// lock is sticky until reset
	assert property (@(posedge clk) disable iff (!arst_n) locked_q |=> locked_q)
		else $error("lock flag cleared without reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(locked_q) |-> res_valid_q && (status_q == ST_RATE_LIMITED))
		else $error("lock taken without a rate limited result");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (status_q == ST_OK) |-> (fail_out_q == '0) && (fail_q == '0))
		else $error("accepted code left failures standing");

	assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> valid_s1 && last_s1 && res_valid_q && result_stall)
		else $error("input stalled without a blocked result");

endmodule

>>> bench/tb_access_code_check_with_lockout_unit.sv
// -----------------------------------------------------------------------------
// Testbench for the access code check with lockout
// Sends candidate codes one character per transfer under varied idling and
// stalling, predicts each verdict with its own copy of the code, lifetime,
// failure counter and lock, and checks results against it or a scripted verdict.
// The lock is sticky until reset, so the lockout is driven last.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_access_code_check_with_lockout_unit;
	import acclk_pkg::*;

	typedef struct packed {
		status_t           st;
		logic [FAIL_W-1:0] fc;
	} verdict_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              hc;
		logic              lst;
		logic [TIME_W-1:0] stamp;
		logic              typed;
		status_t           st;
		logic [FAIL_W-1:0] fc;
	} step_row_t;

	localparam verdict_t NO_VERDICT = '{ST_OK, '0};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  char_valid = 1'b0;
	logic                  char_stall;
	logic [CHAR_W-1:0]     char_code = '0;
	logic                  has_char = 1'b0;
	logic                  is_last = 1'b0;
	logic [TIME_W-1:0]     now_ms = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [1:0]            status;
	logic [FAIL_W-1:0]     failure_count;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// predicted registers and state
	logic [CODE_W-1:0]  cfg_code = '0;
	logic [TIME_W-1:0]  cfg_issue = '0;
	logic [TIME_W-1:0]  cfg_lifetime = LIFETIME_RST;
	logic [LIMIT_W-1:0] cfg_limit = LIMIT_RST;
	logic [CODE_W-1:0]  acc_value = '0;
	logic [COUNT_W-1:0] char_tally = '0;
	logic               junk_seen = 1'b0;
	logic [FAIL_W-1:0]  fail_tally = '0;
	logic               lockout = 1'b0;

	verdict_t    verdicts_due[$];
	step_row_t   script [23];
	int          gap_pct = 0;
	int          stall_pct = 0;
	int unsigned items_sent = 0;
	bit          failed = 1'b0;

	access_code_check_with_lockout_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_code    (char_code),
		.has_char     (has_char),
		.is_last      (is_last),
		.now_ms       (now_ms),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.failure_count(failure_count),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// outputs are stable at the falling edge; a result seen here transfers next edge
	always @(negedge clk) begin
		verdict_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (verdicts_due.size() == 0) begin
				$error("result with no verdict pending: status %0d failure_count %0d",
					status, failure_count);
				failed = 1'b1;
			end else begin
				want = verdicts_due.pop_front();
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					failed = 1'b1;
				end
				if (failure_count !== want.fc) begin
					$error("failure_count: expected %0d, got %0d", want.fc, failure_count);
					failed = 1'b1;
				end
			end
		end
	end

	function automatic bit predict_verdict(input logic [CHAR_W-1:0] ch, input logic hc,
			input logic lst, input logic [TIME_W-1:0] stamp, output verdict_t v);
		logic [23:0] grown;
		v = NO_VERDICT;
		if (hc) begin
			if (char_tally != COUNT_MAX) char_tally = char_tally + COUNT_W'(1);
			if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
				junk_seen = 1'b1;
			end else begin
				grown = 24'(acc_value) * 24'd10 + 24'(ch - CHAR_ZERO);
				// a value past the register width can never match
				if (grown > 24'(ACC_MAX)) begin
					junk_seen = 1'b1;
					acc_value = ACC_MAX;
				end else begin
					acc_value = grown[CODE_W-1:0];
				end
			end
		end
		if (!lst) return 1'b0;
		if (lockout) begin
			v.st = ST_RATE_LIMITED;
		end else if (TIME_W'(stamp - cfg_issue) > cfg_lifetime) begin
			v.st = ST_EXPIRED;
		end else if (char_tally == COUNT_W'(CODE_DIGITS) && !junk_seen
				&& acc_value == cfg_code) begin
			fail_tally = '0;
			v.st = ST_OK;
		end else begin
			if (fail_tally != FAIL_MAX) fail_tally = fail_tally + FAIL_W'(1);
			if (fail_tally >= cfg_limit) begin
				lockout = 1'b1;
				v.st = ST_RATE_LIMITED;
			end else begin
				v.st = ST_INVALID;
			end
		end
		v.fc = fail_tally;
		acc_value = '0;
		char_tally = '0;
		junk_seen = 1'b0;
		return 1'b1;
	endfunction

	// call only in the step of a previous transfer, or with the sender idle
	task automatic push_item(input logic [CHAR_W-1:0] ch, input logic hc, input logic lst,
			input logic [TIME_W-1:0] stamp, input bit use_given, input verdict_t given);
		bit sent;
		verdict_t v;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			char_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		char_valid <= 1'b1;
		char_code <= ch;
		has_char <= hc;
		is_last <= lst;
		now_ms <= stamp;
		do begin
			@(negedge clk);
			sent = !char_stall;
			@(posedge clk);
		end while (!sent);
		items_sent++;
		if (predict_verdict(ch, hc, lst, stamp, v)) verdicts_due.push_back(use_given ? given : v);
	endtask

	task automatic quiesce();
		char_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		// a character with no result may still sit in the input register
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_CODE_VALUE:    cfg_code = data[CODE_W-1:0];
			REG_ISSUE_TIME:    cfg_issue = data[TIME_W-1:0];
			REG_LIFETIME_MS:   cfg_lifetime = data[TIME_W-1:0];
			REG_FAILURE_LIMIT: cfg_limit = data[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	// junk in the unused upper bits must be dropped by the block
	task automatic apply_setup(input logic [CODE_W-1:0] code, input logic [TIME_W-1:0] issue,
			input logic [TIME_W-1:0] life, input logic [LIMIT_W-1:0] limit);
		quiesce();
		write_reg(REG_CODE_VALUE, {12'($urandom), code});
		write_reg(REG_ISSUE_TIME, issue);
		write_reg(REG_LIFETIME_MS, life);
		write_reg(REG_FAILURE_LIMIT, {24'($urandom), limit});
		cfg_we <= 1'b0;
	endtask

	function automatic logic [TIME_W-1:0] next_stamp();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 70) return cfg_issue + $urandom_range(cfg_lifetime);
		if (roll < 80) return cfg_issue + cfg_lifetime;
		if (roll < 90) return cfg_issue + cfg_lifetime + 32'd1;
		return $urandom;
	endfunction

	task automatic send_candidate(input bit fail_only);
		logic [CHAR_W-1:0] chars[$];
		logic [TIME_W-1:0] stamp;
		int unsigned roll, pos, scale;
		bit tail_blank, lst;
		roll = $urandom_range(99);
		scale = 1;
		repeat (CODE_DIGITS - 1) scale *= 10;
		if (fail_only) begin
			// short candidates only: never well formed, so always a failure
			repeat ($urandom_range(3)) chars.push_back(CHAR_ZERO + 8'($urandom_range(9)));
		end else if (roll < 58 || roll >= 88) begin
			// leading zeros past the count limit must not wrap the count
			if (roll < 93 && roll >= 88)
				repeat ($urandom_range(18, 10)) chars.push_back(CHAR_ZERO);
			for (int unsigned s = scale; s != 0; s /= 10)
				chars.push_back(CHAR_ZERO + 8'((cfg_code / s) % 10));
			pos = chars.size() - 1 - $urandom_range(CODE_DIGITS - 1);
			if (roll >= 40 && roll < 58) begin
				chars[pos] = CHAR_ZERO + 8'((chars[pos] - CHAR_ZERO + 1 + $urandom_range(8)) % 10);
			end else if (roll >= 93) begin
				case ($urandom_range(3))
					0: chars[pos] = CHAR_ZERO - 8'd1;
					1: chars[pos] = CHAR_NINE + 8'd1;
					2: chars[pos] = 8'h00;
					default: chars[pos] = 8'hFF;
				endcase
			end
		end else if (roll < 70) begin
			repeat ($urandom_range(9)) chars.push_back(CHAR_ZERO + 8'($urandom_range(9)));
		end else if (roll < 80) begin
			repeat ($urandom_range(8, 1)) chars.push_back(8'($urandom));
		end else begin
			// a leading nine and enough digits to overflow the accumulator
			chars.push_back(CHAR_NINE);
			repeat ($urandom_range(9, 6)) chars.push_back(CHAR_ZERO + 8'($urandom_range(9)));
		end
		stamp = next_stamp();
		tail_blank = (chars.size() == 0) || ($urandom_range(3) == 0);
		foreach (chars[i]) begin
			if ($urandom_range(99) < 15)
				push_item(8'($urandom), 1'b0, 1'b0, $urandom, 1'b0, NO_VERDICT);
			lst = (i == chars.size() - 1) && !tail_blank;
			push_item(chars[i], 1'b1, lst, lst ? stamp : TIME_W'($urandom), 1'b0, NO_VERDICT);
		end
		if (tail_blank) push_item(8'($urandom), 1'b0, 1'b1, stamp, 1'b0, NO_VERDICT);
	endtask

	task automatic run_phase(input int gap, input int stall, input int unsigned count);
		int unsigned target;
		gap_pct = gap;
		stall_pct = stall;
		target = items_sent + count;
		while (items_sent < target) send_candidate(1'b0);
	endtask

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		// reset registers: code 0, issue 0, lifetime 300000, limit 5
		script = '{
			'{8'h00, 1'b0, 1'b1, 32'd0,       1'b1, ST_INVALID, 8'd1},  // empty candidate
			'{"0",   1'b1, 1'b0, 32'd0,       1'b0, ST_OK,      8'd0},
			'{"0",   1'b1, 1'b0, 32'd0,       1'b0, ST_OK,      8'd0},
			'{"0",   1'b1, 1'b0, 32'd0,       1'b0, ST_OK,      8'd0},
			'{"0",   1'b1, 1'b0, 32'd0,       1'b0, ST_OK,      8'd0},
			'{"0",   1'b1, 1'b0, 32'd0,       1'b0, ST_OK,      8'd0},
			'{"0",   1'b1, 1'b1, 32'd300000,  1'b1, ST_OK,      8'd0},  // age on the limit
			'{8'hFF, 1'b1, 1'b0, 32'd0,       1'b0, ST_OK,      8'd0},
			'{"5",   1'b1, 1'b1, 32'hFFFFFFFF, 1'b1, ST_EXPIRED, 8'd0},
			'{8'h00, 1'b1, 1'b1, 32'd1,       1'b1, ST_INVALID, 8'd1},  // NUL is no digit
			'{"/",   1'b1, 1'b0, 32'd0,       1'b0, ST_OK,      8'd0},
			'{"0",   1'b1, 1'b0, 32'd0,       1'b0, ST_OK,      8'd0},
			'{"x",   1'b0, 1'b0, 32'd0,       1'b0, ST_OK,      8'd0},  // no character
			'{"0",   1'b1, 1'b0, 32'd0,       1'b0, ST_OK,      8'd0},
			'{":",   1'b1, 1'b0, 32'd0,       1'b0, ST_OK,      8'd0},
			'{"0",   1'b1, 1'b0, 32'd0,       1'b0, ST_OK,      8'd0},
			'{"9",   1'b1, 1'b1, 32'd100,     1'b1, ST_INVALID, 8'd2},
			'{"9",   1'b1, 1'b0, 32'd0,       1'b0, ST_OK,      8'd0},
			'{"9",   1'b1, 1'b0, 32'd0,       1'b0, ST_OK,      8'd0},
			'{"9",   1'b1, 1'b0, 32'd0,       1'b0, ST_OK,      8'd0},
			'{"9",   1'b1, 1'b0, 32'd0,       1'b0, ST_OK,      8'd0},
			'{"9",   1'b1, 1'b0, 32'd0,       1'b0, ST_OK,      8'd0},
			'{"9",   1'b1, 1'b1, 32'd300000,  1'b1, ST_INVALID, 8'd3}
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			push_item(script[i].ch, script[i].hc, script[i].lst, script[i].stamp,
				script[i].typed, verdict_t'{script[i].st, script[i].fc});

		apply_setup(20'd999999, 32'd0, 32'hFFFFFFFF, 8'd255);
		run_phase(0, 0, 100);
		apply_setup(CODE_W'($urandom_range(999999)), $urandom,
			$urandom_range(100000, 1), 8'd200);
		run_phase(85, 0, 100);
		apply_setup(20'd0, 32'hFFFFFFF0, 32'd1000, 8'd255);
		run_phase(0, 85, 100);
		apply_setup(CODE_W'($urandom_range(999999)), 32'hFFFFFFFF, 32'd0, 8'd128);
		run_phase(30, 30, 100);

		// lockout: pile up failures, then a zero limit locks on the next one
		apply_setup(CODE_W'($urandom_range(999999)), $urandom, 32'hFFFFFFFF, 8'd255);
		gap_pct = 0;
		stall_pct = 0;
		while (fail_tally < 8'd254 && !lockout) send_candidate(1'b1);
		quiesce();
		write_reg(REG_FAILURE_LIMIT, {24'($urandom), 8'd0});
		cfg_we <= 1'b0;
		send_candidate(1'b1);
		gap_pct = 50;
		stall_pct = 50;
		repeat (10) send_candidate(1'b0);

		quiesce();
		if (failed) begin
			$display("SCOREBOARD MISMATCH");
		end else begin
			$display("SCOREBOARD CLEAN");
		end
		$finish;
	end

endmodule
